// ===== src/srf_pkg.sv =====
package srf_pkg;

  localparam int unsigned QuoW = 17;
  localparam int unsigned NumW = 50;
  localparam int unsigned DenW = 34;
  localparam int unsigned CosW = 18;
  localparam int unsigned SqrW = 35;
  localparam int unsigned XW   = 18;
  localparam int unsigned PW   = 22;
  localparam int unsigned PowStages = 4;

  localparam logic [QuoW-1:0] OneQ16 = 17'h10000;

  typedef struct packed {
    logic [NumW-1:0]        rem_a;
    logic [QuoW-1:0]        quo_a;
    logic [DenW-1:0]        den_a;
    logic [NumW-1:0]        rem_b;
    logic [QuoW-1:0]        quo_b;
    logic [DenW-1:0]        den_b;
    logic signed [CosW-1:0] cos;
    logic                   use_sqrt;
    logic                   tir;
    logic                   s_zero;
  } srf_div_t;

  typedef struct packed {
    logic [SqrW-1:0]        rem;
    logic [QuoW-1:0]        root;
    logic signed [CosW-1:0] cos;
    logic                   use_sqrt;
    logic                   tir;
    logic [QuoW-1:0]        r0;
  } srf_sqrt_t;

  typedef struct packed {
    logic [XW-1:0]   x;
    logic [PW-1:0]   p;
    logic [QuoW-1:0] r0;
    logic            tir;
  } srf_pow_t;

endpackage

// ===== src/schlick_reflectance_core.sv =====
// Schlick reflectance pipeline.
// Input transactions carry an eye vector and a surface normal (signed Q2.14)
// and the refractive indices of both media (unsigned Q4.12). Each accepted
// transaction yields exactly one output transaction with the reflectance in
// unsigned Q1.16 and a total internal reflection flag.
// The pipeline accepts one transaction per cycle unless stalled. It has 43
// register stages: four front stages for the dot product, clamping and index
// products, a row of 17 division cells, a row of 17 square root cells, four
// power cells and the output register.
// All stages share one enable. When the output register holds a transaction
// that the receiver does not take, the whole pipeline holds and in_ready_o
// falls; it follows out_ready_i in the same cycle, so it is high again in the
// cycle in which the receiver takes the result.
// Reset clears every valid bit, so the pipeline comes up empty and ready.
module schlick_reflectance_core
  import srf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] eye_x_i,
  input  logic signed [15:0] eye_y_i,
  input  logic signed [15:0] eye_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]        index_from_i,
  input  logic [15:0]        index_to_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        reflectance_o,
  output logic               total_reflection_o
);

  localparam int unsigned Steps = QuoW;
  localparam logic signed [33:0] One28 = 34'sd268435456;

  logic en;
  logic out_valid_q;
  logic [16:0] refl_q;
  logic tir_q;

  assign en = !out_valid_q || out_ready_i;

  // Stage 1: products.
  logic s1_valid_q;
  logic signed [31:0] s1_px_q, s1_py_q, s1_pz_q;
  logic [31:0] s1_n1sq_q, s1_n2sq_q;
  logic [15:0] s1_d_q;
  logic [16:0] s1_s_q;
  logic s1_gt_q, s1_n2z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_px_q   <= eye_x_i * normal_x_i;
      s1_py_q   <= eye_y_i * normal_y_i;
      s1_pz_q   <= eye_z_i * normal_z_i;
      s1_n1sq_q <= index_from_i * index_from_i;
      s1_n2sq_q <= index_to_i * index_to_i;
      s1_d_q    <= (index_from_i > index_to_i) ? index_from_i - index_to_i
                                               : index_to_i - index_from_i;
      s1_s_q    <= 17'(index_from_i) + 17'(index_to_i);
      s1_gt_q   <= index_from_i > index_to_i;
      s1_n2z_q  <= index_to_i == 16'd0;
    end
  end

  // Stage 2: dot product, clamp, cosine; squares of difference and sum.
  logic signed [33:0] dot, dot_cl;
  logic [33:0] dot_off;
  logic signed [18:0] cos_w;
  logic s2_valid_q;
  logic signed [CosW-1:0] s2_cos_q;
  logic [31:0] s2_n1sq_q, s2_n2sq_q, s2_dsq_q;
  logic [DenW-1:0] s2_ssq_q;
  logic s2_gt_q, s2_n2z_q, s2_sz_q;

  always_comb begin
    dot    = 34'(s1_px_q) + 34'(s1_py_q) + 34'(s1_pz_q);
    dot_cl = dot;
    if (dot > One28) begin
      dot_cl = One28;
    end else if (dot < -One28) begin
      dot_cl = -One28;
    end
    dot_off = dot_cl + One28;
    cos_w   = $signed({1'b0, dot_off[29:12]}) - 19'sd65536;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cos_q  <= cos_w[CosW-1:0];
      s2_n1sq_q <= s1_n1sq_q;
      s2_n2sq_q <= s1_n2sq_q;
      s2_dsq_q  <= s1_d_q * s1_d_q;
      s2_ssq_q  <= s1_s_q * s1_s_q;
      s2_gt_q   <= s1_gt_q;
      s2_n2z_q  <= s1_n2z_q;
      s2_sz_q   <= s1_s_q == 17'd0;
    end
  end

  // Stage 3: squared cosine magnitude.
  logic [16:0] cmag;
  logic s3_valid_q;
  logic [33:0] s3_csq_q;
  logic signed [CosW-1:0] s3_cos_q;
  logic [31:0] s3_n1sq_q, s3_n2sq_q, s3_dsq_q;
  logic [DenW-1:0] s3_ssq_q;
  logic s3_gt_q, s3_n2z_q, s3_sz_q;

  assign cmag = s2_cos_q[CosW-1] ? 17'(-s2_cos_q) : 17'(s2_cos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_csq_q  <= cmag * cmag;
      s3_cos_q  <= s2_cos_q;
      s3_n1sq_q <= s2_n1sq_q;
      s3_n2sq_q <= s2_n2sq_q;
      s3_dsq_q  <= s2_dsq_q;
      s3_ssq_q  <= s2_ssq_q;
      s3_gt_q   <= s2_gt_q;
      s3_n2z_q  <= s2_n2z_q;
      s3_sz_q   <= s2_sz_q;
    end
  end

  // Stage 4: scaled squared sine before the index ratio.
  logic [32:0] one_minus;
  logic [16:0] t_val;
  logic s4_valid_q;
  logic [48:0] s4_lhs_q;
  logic signed [CosW-1:0] s4_cos_q;
  logic [31:0] s4_n2sq_q, s4_dsq_q;
  logic [DenW-1:0] s4_ssq_q;
  logic s4_gt_q, s4_n2z_q, s4_sz_q;

  assign one_minus = 33'h1_0000_0000 - 33'(s3_csq_q);
  assign t_val     = one_minus[32:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_lhs_q  <= s3_n1sq_q * t_val;
      s4_cos_q  <= s3_cos_q;
      s4_n2sq_q <= s3_n2sq_q;
      s4_dsq_q  <= s3_dsq_q;
      s4_ssq_q  <= s3_ssq_q;
      s4_gt_q   <= s3_gt_q;
      s4_n2z_q  <= s3_n2z_q;
      s4_sz_q   <= s3_sz_q;
    end
  end

  // Division row: squared sine and r0 side by side.
  logic     tir_det;
  srf_div_t div_data [Steps+1];
  logic     div_valid [Steps+1];

  assign tir_det = s4_gt_q && (s4_n2z_q || (s4_lhs_q > {1'b0, s4_n2sq_q, 16'd0}));

  always_comb begin
    div_valid[0]         = s4_valid_q;
    div_data[0].rem_a    = NumW'(s4_lhs_q);
    div_data[0].quo_a    = '0;
    div_data[0].den_a    = DenW'(s4_n2sq_q);
    div_data[0].rem_b    = NumW'({s4_dsq_q, 16'd0});
    div_data[0].quo_b    = '0;
    div_data[0].den_b    = s4_ssq_q;
    div_data[0].cos      = s4_cos_q;
    div_data[0].use_sqrt = s4_gt_q && !tir_det;
    div_data[0].tir      = tir_det;
    div_data[0].s_zero   = s4_sz_q;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    srf_div_cell #(
      .STEP(Steps - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(div_valid[k]),
      .data_i (div_data[k]),
      .valid_o(div_valid[k+1]),
      .data_o (div_data[k+1])
    );
  end

  // Square root row for the transmitted cosine.
  srf_div_t  div_last;
  srf_sqrt_t sqr_data [Steps+1];
  logic      sqr_valid [Steps+1];
  logic [QuoW-1:0] cos_sq;

  assign div_last = div_data[Steps];
  assign cos_sq   = OneQ16 - div_last.quo_a;

  always_comb begin
    sqr_valid[0]         = div_valid[Steps];
    sqr_data[0].rem      = SqrW'({cos_sq, 16'd0});
    sqr_data[0].root     = '0;
    sqr_data[0].cos      = div_last.cos;
    sqr_data[0].use_sqrt = div_last.use_sqrt;
    sqr_data[0].tir      = div_last.tir;
    sqr_data[0].r0       = div_last.s_zero ? '0 : div_last.quo_b;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_sqrt
    srf_sqrt_cell #(
      .STEP(Steps - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sqr_valid[k]),
      .data_i (sqr_data[k]),
      .valid_o(sqr_valid[k+1]),
      .data_o (sqr_data[k+1])
    );
  end

  // Power row: fifth power of one minus the cosine.
  srf_sqrt_t sqr_last;
  logic signed [18:0] cos_sel, x_w;
  srf_pow_t  pow_data [PowStages+1];
  logic      pow_valid [PowStages+1];

  assign sqr_last = sqr_data[Steps];

  always_comb begin
    cos_sel = sqr_last.use_sqrt ? $signed({2'b00, sqr_last.root})
                                : 19'(sqr_last.cos);
    x_w     = 19'sd65536 - cos_sel;
    pow_valid[0]    = sqr_valid[Steps];
    pow_data[0].x   = x_w[XW-1:0];
    pow_data[0].p   = PW'(x_w[XW-1:0]);
    pow_data[0].r0  = sqr_last.r0;
    pow_data[0].tir = sqr_last.tir;
  end

  for (genvar k = 0; k < PowStages; k++) begin : g_pow
    srf_pow_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(pow_valid[k]),
      .data_i (pow_data[k]),
      .valid_o(pow_valid[k+1]),
      .data_o (pow_data[k+1])
    );
  end

  // Output register.
  srf_pow_t pow_last;
  logic [QuoW+PW-1:0] blend;
  logic [23:0] sum;
  logic [16:0] refl_d;

  assign pow_last = pow_data[PowStages];

  always_comb begin
    blend = (OneQ16 - pow_last.r0) * pow_last.p;
    sum   = 24'(pow_last.r0) + 24'(blend[QuoW+PW-1:16]);
    if (pow_last.tir || sum > 24'(OneQ16)) begin
      refl_d = OneQ16;
    end else begin
      refl_d = sum[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pow_valid[PowStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      refl_q <= refl_d;
      tir_q  <= pow_last.tir;
    end
  end

  assign in_ready_o         = en;
  assign out_valid_o        = out_valid_q;
  assign reflectance_o      = refl_q;
  assign total_reflection_o = tir_q;

endmodule

// ===== src/srf_div_cell.sv =====
module srf_div_cell
  import srf_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  srf_div_t data_i,
  output logic     valid_o,
  output srf_div_t data_o
);

  logic     valid_q;
  srf_div_t data_d, data_q;
  logic [NumW-1:0] sh_a, sh_b;

  always_comb begin
    data_d = data_i;
    sh_a   = NumW'(data_i.den_a) << STEP;
    sh_b   = NumW'(data_i.den_b) << STEP;
    if (data_i.rem_a >= sh_a) begin
      data_d.rem_a       = data_i.rem_a - sh_a;
      data_d.quo_a[STEP] = 1'b1;
    end
    if (data_i.rem_b >= sh_b) begin
      data_d.rem_b       = data_i.rem_b - sh_b;
      data_d.quo_b[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/srf_sqrt_cell.sv =====
module srf_sqrt_cell
  import srf_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  srf_sqrt_t data_i,
  output logic      valid_o,
  output srf_sqrt_t data_o
);

  logic      valid_q;
  srf_sqrt_t data_d, data_q;
  logic [SqrW-1:0] trial;

  always_comb begin
    data_d = data_i;
    trial  = (SqrW'(data_i.root) << (STEP + 1)) + (SqrW'(1) << (2 * STEP));
    if (data_i.rem >= trial) begin
      data_d.rem        = data_i.rem - trial;
      data_d.root[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/srf_pow_cell.sv =====
module srf_pow_cell
  import srf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  srf_pow_t data_i,
  output logic     valid_o,
  output srf_pow_t data_o
);

  logic     valid_q;
  srf_pow_t data_d, data_q;
  logic [PW+XW-1:0] prod;

  always_comb begin
    data_d   = data_i;
    prod     = data_i.p * data_i.x;
    data_d.p = prod[PW+15:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import srf_pkg::*;

  typedef struct {
    logic signed [15:0] eye_x;
    logic signed [15:0] eye_y;
    logic signed [15:0] eye_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [15:0]        n_from;
    logic [15:0]        n_to;
  } hit_t;

  typedef struct {
    logic [16:0] refl;
    logic        tir;
  } refl_t;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned DrainCycles   = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] refl_o;
  logic        tir_o;
  hit_t        drv_hit = '{default: '0};

  hit_t  pending_q[$];
  refl_t expected_q[$];

  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned n_tir = 0;
  int unsigned n_sat = 0;
  int unsigned n_err = 0;
  int unsigned drv_gap = 0;
  int unsigned rcv_hold = 0;
  bit          long_done = 1'b0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  schlick_reflectance_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .eye_x_i           (drv_hit.eye_x),
    .eye_y_i           (drv_hit.eye_y),
    .eye_z_i           (drv_hit.eye_z),
    .normal_x_i        (drv_hit.nrm_x),
    .normal_y_i        (drv_hit.nrm_y),
    .normal_z_i        (drv_hit.nrm_z),
    .index_from_i      (drv_hit.n_from),
    .index_to_i        (drv_hit.n_to),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .reflectance_o     (refl_o),
    .total_reflection_o(tir_o)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic refl_t schlick_of(hit_t h);
    longint          dot;
    longint          c;
    longint          one28;
    longint unsigned n1, n2, cmag, t, lhs, rhs, sin2, r0, d, s, x, p, r;
    refl_t           res;
    one28 = longint'(1) << 28;
    dot = longint'(h.eye_x) * longint'(h.nrm_x) + longint'(h.eye_y) * longint'(h.nrm_y) +
          longint'(h.eye_z) * longint'(h.nrm_z);
    if (dot > one28) dot = one28;
    if (dot < -one28) dot = -one28;
    c = ((dot + one28) >>> 12) - 65536;
    n1 = h.n_from;
    n2 = h.n_to;
    res.tir = 1'b0;
    if (n1 > n2) begin
      if (n2 == 0) begin
        res.refl = OneQ16;
        res.tir = 1'b1;
        return res;
      end
      cmag = (c < 0) ? -c : c;
      t = ((64'd1 << 32) - cmag * cmag) >> 16;
      lhs = n1 * n1 * t;
      rhs = (n2 * n2) << 16;
      if (lhs > rhs) begin
        res.refl = OneQ16;
        res.tir = 1'b1;
        return res;
      end
      sin2 = lhs / (n2 * n2);
      c = longint'(int_sqrt((64'd65536 - sin2) << 16));
    end
    if (n1 + n2 == 0) begin
      r0 = 0;
    end else begin
      d = (n1 > n2) ? n1 - n2 : n2 - n1;
      s = n1 + n2;
      r0 = ((d * d) << 16) / (s * s);
    end
    x = longint'(65536) - c;
    p = x;
    for (int k = 0; k < 4; k++) p = (p * x) >> 16;
    r = r0 + (((64'd65536 - r0) * p) >> 16);
    if (r > 65536) r = 65536;
    res.refl = r[16:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic add_hit(int ex, int ey, int ez, int nx, int ny, int nz, int n1, int n2);
    hit_t h;
    h.eye_x = 16'(ex);
    h.eye_y = 16'(ey);
    h.eye_z = 16'(ez);
    h.nrm_x = 16'(nx);
    h.nrm_y = 16'(ny);
    h.nrm_z = 16'(nz);
    h.n_from = 16'(n1);
    h.n_to = 16'(n2);
    pending_q.push_back(h);
  endtask

  function automatic int near_unit();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic int rand_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(4096, 12288);
    if (r < 70) return 0;
    return $urandom_range(0, 65535);
  endfunction

  // Driver: offers queued transactions with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      drv_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(schlick_of(drv_hit));
        n_sent++;
      end
      if (in_valid && !in_ready) begin
      end else if (drv_gap > 0) begin
        in_valid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pending_q.size() > 0) begin
        drv_hit <= pending_q.pop_front();
        in_valid <= 1'b1;
        drv_gap <= ((n_sent / 60) % 3 == 1) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: takes results with random stalls and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned g;
    refl_t       exp_r;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rcv_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_recv++;
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("ERROR: unexpected transaction refl=%0d tir=%0b",
                                    refl_o, tir_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.tir) n_tir++;
          if (!exp_r.tir && exp_r.refl == OneQ16) n_sat++;
          if (refl_o !== exp_r.refl || tir_o !== exp_r.tir) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: transaction %0d refl exp %0d got %0d, tir exp %0b got %0b",
                       n_recv, exp_r.refl, refl_o, exp_r.tir, tir_o);
          end
        end
      end
      if (rcv_hold > 0) begin
        out_ready <= 1'b0;
        rcv_hold <= rcv_hold - 1;
      end else if (!long_done && n_recv >= 120) begin
        long_done = 1'b1;
        out_ready <= 1'b0;
        rcv_hold <= LongHold;
      end else begin
        g = ((n_recv / 70) % 3 == 2) ? 0 : pick_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rcv_hold <= g - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("schlick_reflectance_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    add_hit(0, 0, 16384, 0, 0, 16384, 4096, 6144);
    add_hit(16384, 0, 0, 0, 0, 16384, 4096, 6144);
    add_hit(0, 0, -16384, 0, 0, 16384, 4096, 6144);
    add_hit(11585, 0, 11585, 0, 0, 16384, 6144, 4096);
    add_hit(0, 0, 16384, 0, 0, 16384, 6144, 4096);
    add_hit(1000, 2000, 16000, 0, 0, 16384, 4096, 0);
    add_hit(0, 16384, 0, 0, 16384, 0, 0, 0);
    add_hit(3000, -5000, 9000, 100, 16000, -200, 5000, 5000);
    add_hit(-32768, -32768, -32768, -32768, -32768, -32768, 4096, 6144);
    add_hit(32767, 32767, 32767, 32767, 32767, 32767, 6144, 4096);
    add_hit(-32768, 32767, -32768, 32767, -32768, 32767, 4096, 4096);
    add_hit(0, 0, 16384, 0, 0, 16384, 65535, 65534);
    add_hit(0, 0, 16384, 0, 0, 16384, 65535, 1);
    add_hit(0, 0, 16384, 0, 0, 16384, 0, 65535);
    add_hit(0, 0, 16384, 0, 0, 16384, 1, 0);
    add_hit(0, 0, 0, 0, 0, 0, 6144, 4096);
    add_hit(0, 0, 0, 0, 0, 0, 4096, 6144);
    add_hit(-16384, 0, 0, 16384, 0, 0, 6144, 4096);
    add_hit(16384, 0, 0, 16384, 0, 0, 65535, 65535);
    add_hit(8192, 8192, 8192, 8192, 8192, 8192, 5461, 4096);
    for (int i = 0; i < 450; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_hit(near_unit(), near_unit(), near_unit(), near_unit(), near_unit(),
                near_unit(), rand_index(), rand_index());
      end else begin
        add_hit($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (out_valid) n_err++;
    $display("Sent %0d transactions and checked %0d results.", n_sent, n_recv);
    $display("Total reflection in %0d results, saturation in %0d, errors %0d.",
             n_tir, n_sat, n_err);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("schlick_reflectance_core: match");
    end else begin
      $display("schlick_reflectance_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== schlick_reflectance_core.f =====
src/srf_pkg.sv
src/srf_div_cell.sv
src/srf_sqrt_cell.sv
src/srf_pow_cell.sv
src/schlick_reflectance_core.sv
tb/sv/testbench.sv
